### rtl/core/bdq_pkg.sv
// shared types and codes for the bounded deque with reverse
package bdq_pkg;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_INS_HEAD = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_REM_HEAD = 2'd2,
    OP_REVERSE  = 2'd3
  } bdq_op_t;

  // status codes of a result transaction
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bdq_status_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    bdq_op_t                   operation;
    logic signed [DATA_W-1:0]  item_value;
  } bdq_in_t;

  typedef struct packed {
    bdq_status_t               status;
    logic signed [DATA_W-1:0]  removed_value;
    logic [COUNT_W-1:0]        entry_count;
  } bdq_out_t;

  // store access strobes from control to the ring store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } bdq_mem_ctl_t;

endpackage

### rtl/core/bounded_deque_with_reverse_top.sv
// top level of the bounded deque with reverse: control, ring store, result register
//
// channel  direction  handshake                 payload
// -------  ---------  ------------------------  -----------------------------------
// in       input      start high, busy low      in_item    (operation, item_value)
// out      output     out_strobe for one cycle  out_result (status, removed_value,
//                                                            entry_count)
//
// one transaction is taken every cycle; busy stays low
// the result of a transaction shows in the cycle after its acceptance; the removed
// value comes from the registered read port of the ring store
// synchronous active-low reset clears front index, count, direction and strobe;
// the ring store is not cleared, entries are only read once written
// the receiver cannot hold results off, so nothing ever stalls
module bounded_deque_with_reverse_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bdq_pkg::bdq_in_t   in_item,
  output logic               out_strobe,
  output bdq_pkg::bdq_out_t  out_result
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                          accept;
  bdq_pkg::bdq_mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0]              wr_addr, rd_addr;
  logic [bdq_pkg::DATA_W-1:0]    rd_data;
  bdq_pkg::bdq_status_t          status;
  logic [CNT_W-1:0]              count_after;
  logic [31:0]                   count_wide;

  // result register, the removed value itself comes from the store's read register
  logic                          strobe_r;
  bdq_pkg::bdq_status_t          status_r;
  logic [bdq_pkg::COUNT_W-1:0]   count_r;
  logic                          removed_r;

  // every cycle is open for a new transaction
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  bdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_item),
    .mem_ctl     (mem_ctl),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .status      (status),
    .count_after (count_after)
  );

  bdq_ring_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (in_item.item_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // count reported modulo 32 whatever the depth
  assign count_wide = 32'(count_after);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status;
      count_r   <= count_wide[bdq_pkg::COUNT_W-1:0];
      removed_r <= mem_ctl.rd_en;
    end
  end

  assign out_strobe               = strobe_r;
  assign out_result.status        = status_r;
  assign out_result.removed_value = removed_r ? rd_data : '0;
  assign out_result.entry_count   = count_r;

endmodule

### rtl/core/bdq_ring_mem.sv
// ring store: one write port, one read port with registered read data
module bdq_ring_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  bdq_pkg::bdq_mem_ctl_t             mem_ctl,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [bdq_pkg::DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic [bdq_pkg::DATA_W-1:0]        rd_data
);

  logic [bdq_pkg::DATA_W-1:0] store_r [DEPTH];
  logic [bdq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/bdq_ctrl.sv
// pointer, count and direction state with the per-transaction decode
module bdq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  bdq_pkg::bdq_in_t                       item,
  output bdq_pkg::bdq_mem_ctl_t                  mem_ctl,
  output logic [$clog2(DEPTH)-1:0]               wr_addr,
  output logic [$clog2(DEPTH)-1:0]               rd_addr,
  output bdq_pkg::bdq_status_t                   status,
  output logic [$clog2(DEPTH+1)-1:0]             count_after
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rev_r, rev_nxt;

  logic             full, empty, at_front;
  logic [IDX_W-1:0] front_dec, front_inc, back_slot, last_slot;
  logic [SUM_W-1:0] back_sum, last_sum;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  // a head insert lands at the physical front unless the order is reversed
  assign at_front = (item.operation == bdq_pkg::OP_INS_HEAD) ^ rev_r;

  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + IDX_W'(1);

  // slot just past the physical back, and the last occupied slot
  assign back_sum  = SUM_W'(front_r) + SUM_W'(count_r);
  assign last_sum  = back_sum - SUM_W'(1);
  assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(back_sum);
  assign last_slot = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(last_sum);

  always_comb begin
    front_nxt   = front_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    mem_ctl     = '0;
    wr_addr     = back_slot;
    rd_addr     = front_r;
    status      = bdq_pkg::ST_OK;
    unique case (item.operation) inside
      bdq_pkg::OP_INS_HEAD, bdq_pkg::OP_INS_TAIL: begin
        if (full) begin
          status = bdq_pkg::ST_FULL;
        end else begin
          mem_ctl.wr_en = accept;
          count_nxt     = count_r + CNT_W'(1);
          if (at_front) begin
            front_nxt = front_dec;
            wr_addr   = front_dec;
          end
        end
      end
      bdq_pkg::OP_REM_HEAD: begin
        if (empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          mem_ctl.rd_en = accept;
          count_nxt     = count_r - CNT_W'(1);
          if (rev_r) begin
            rd_addr = last_slot;
          end else begin
            front_nxt = front_inc;
          end
        end
      end
      bdq_pkg::OP_REVERSE: begin
        rev_nxt = ~rev_r;
      end
      default: begin
        status = bdq_pkg::ST_OK;
      end
    endcase
  end

  assign count_after = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (accept) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

endmodule
